[src/tdf_pkg.sv]
// Shared constants for the trial division factorizer.
`default_nettype none

package tdf_pkg;

  // Operand width of the value, the factors and the shared divider.
  localparam int WIDTH = 32;
  // Step counter width of the divider: counts WIDTH-1 down to 0.
  localparam int STEP_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;

  // Result of one division as handed from the divider to the sequencer.
  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_result_t;

endpackage

`default_nettype wire

[src/trial_division_factorizer_unit.sv]
// Top level: trial division sequencer around a shared iterative divider.
//
// Usage: present an unsigned value on value_i with in_valid_i; it is taken at
// a rising edge where in_valid_i is high and in_stall_o is low. The block
// then emits the prime factors in ascending order, with repeats, on factor_o,
// one transaction each, with last_o high on the final one. Values 0 and 1
// come back unchanged as a single transaction with last_o set.
// Operation: each candidate divisor costs one division (launch, WIDTH divider
// steps, result handoff, decision). Candidates run from 2 up to the square
// root of the shrinking remainder, and each factor found costs one more
// division of the same candidate.
// in_stall_o stays high from acceptance until the last factor has been loaded
// into the output register; the next item can enter while that one waits.
// The output register holds its transaction while out_stall_i is high and the
// sequencer pauses until the register frees up. Reset empties the output
// register and returns the sequencer to idle; no data is kept across items.
`default_nettype none

module trial_division_factorizer_unit
  import tdf_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire word_t value_i,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output word_t      factor_o,
  output logic       last_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StStart  = 3'd1;
  localparam logic [2:0] StWait   = 3'd2;
  localparam logic [2:0] StDecide = 3'd3;
  localparam logic [2:0] StFinal  = 3'd4;

  logic [2:0]  state_q, state_d;
  word_t       rest_q, rest_d;
  word_t       cand_q, cand_d;
  logic        out_valid_q, out_valid_d;
  word_t       factor_q, factor_d;
  logic        last_q, last_d;

  logic        div_start;
  div_result_t div_res;
  logic        out_free;
  logic        emit;

  tdf_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rest_q),
    .divisor_i  (cand_q),
    .result_o   (div_res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d   = state_q;
    rest_d    = rest_q;
    cand_d    = cand_q;
    factor_d  = factor_q;
    last_d    = last_q;
    emit      = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          rest_d = value_i;
          cand_d = WIDTH'(2);
          if (value_i < WIDTH'(2)) begin
            state_d = StFinal;
          end else begin
            state_d = StStart;
          end
        end
      end
      StStart: begin
        div_start = 1'b1;
        state_d   = StWait;
      end
      StWait: begin
        if (div_res.done) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (cand_q > div_res.quotient) begin
          // candidate squared exceeds the remainder: remainder is the last factor
          state_d = StFinal;
        end else if (div_res.remainder == '0) begin
          if (out_free) begin
            emit     = 1'b1;
            factor_d = cand_q;
            last_d   = (div_res.quotient == WIDTH'(1));
            rest_d   = div_res.quotient;
            state_d  = (div_res.quotient == WIDTH'(1)) ? StIdle : StStart;
          end
        end else begin
          cand_d  = cand_q + WIDTH'(1);
          state_d = StStart;
        end
      end
      StFinal: begin
        if (out_free) begin
          emit     = 1'b1;
          factor_d = rest_q;
          last_d   = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q   <= rest_d;
    cand_q   <= cand_d;
    factor_q <= factor_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign factor_o    = factor_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

[src/tdf_divider.sv]
// Restoring radix-2 divider: one quotient bit per cycle, WIDTH quotient bits per division.
`default_nettype none

module tdf_divider
  import tdf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire word_t       dividend_i,
  input  wire word_t       divisor_i,
  output div_result_t      result_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  word_t             rem_q, rem_d;
  word_t             quo_q, quo_d;
  word_t             dsr_q, dsr_d;

  logic [WIDTH:0]    rem_shift;
  logic [WIDTH:0]    diff;

  assign rem_shift = {rem_q, quo_q[WIDTH-1]};
  assign diff      = rem_shift - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(WIDTH - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // keep the trial difference only when it did not go negative
      if (!diff[WIDTH]) begin
        rem_d = diff[WIDTH-1:0];
      end else begin
        rem_d = rem_shift[WIDTH-1:0];
      end
      quo_d = {quo_q[WIDTH-2:0], ~diff[WIDTH]};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign result_o.done      = done_q;
  assign result_o.quotient  = quo_q;
  assign result_o.remainder = rem_q;

endmodule

`default_nettype wire
